### hw/rtl/skti_pkg.sv
package skti_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned TREE_LVL = $clog2(CAPACITY);
  localparam int unsigned TREE_N   = 1 << TREE_LVL;
  localparam int unsigned LAT      = TREE_LVL + 1;
  localparam int unsigned LAT_W    = $clog2(LAT + 1);

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_FOUND    = 2'd2,
    STATUS_MISSING  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] page;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [31:0] page;
    logic [31:0] offset;
  } hit_t;

  typedef struct packed {
    logic        ins_en;
    entry_t      ins;
    logic [31:0] query;
  } cell_ctl_t;

  typedef struct packed {
    logic in_use;
    logic at_end;
  } cell_pos_t;

  typedef struct packed {
    entry_t entry;
    logic   gt;
    logic   eq;
  } link_t;

  function automatic hit_t hit_or(input hit_t a, input hit_t b);
    hit_t r;
    r.found  = a.found | b.found;
    r.page   = a.page | b.page;
    r.offset = a.offset | b.offset;
    return r;
  endfunction

endpackage

### hw/rtl/sorted_key_index_table_unit.sv
// Channel  Dir  tdata (low bit up)                      tuser
// s_axis   in   key[31:0], page_in[31:0], offset_in    mode (1 bit)
// m_axis   out  page_out[31:0], offset_out[31:0]       status (2 bits)
//
// Insert: one beat per cycle unless m_axis stalls; result the next cycle.
// Search: the result passes the query register, the cell hit register, the
// registered OR tree over the cell hits and the output register; no input
// beat is taken until the output register is loaded.
// Reset clears the state, the entry count and the output valid flag; cell contents stay.
// A result waiting on m_axis stalls further input until it is taken.
module sorted_key_index_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // key, page_in, offset_in
  input  logic [0:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // page_out, offset_out
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int unsigned N = skti_pkg::CAPACITY;

  skti_pkg::state_e          state_q, state_d;
  logic [skti_pkg::CNT_W-1:0] count_q, count_d;
  logic [skti_pkg::LAT_W-1:0] lat_q, lat_d;
  logic [31:0]               query_q, query_d;
  logic                      out_valid_q, out_valid_d;
  skti_pkg::status_e         out_status_q, out_status_d;
  logic [31:0]               out_page_q, out_page_d;
  logic [31:0]               out_offset_q, out_offset_d;

  logic              out_free, accept, is_search, full, ins_en, done;
  skti_pkg::cell_ctl_t ctl;
  skti_pkg::cell_pos_t pos  [N];
  skti_pkg::link_t     link [N];
  skti_pkg::link_t     left [N];
  skti_pkg::hit_t      leaf [N];
  skti_pkg::hit_t      root;

  assign out_free  = ~out_valid_q | m_axis_tready;
  assign accept    = s_axis_tvalid & s_axis_tready;
  assign is_search = (s_axis_tuser == skti_pkg::MODE_SEARCH);
  assign full      = (count_q == skti_pkg::CNT_W'(N));
  assign ins_en    = accept & ~is_search & ~full;
  assign done      = (state_q == skti_pkg::ST_SEARCH) &&
                     (lat_q == skti_pkg::LAT_W'(skti_pkg::LAT)) && out_free;

  assign ctl.ins_en     = ins_en;
  assign ctl.ins.key    = s_axis_tdata[31:0];
  assign ctl.ins.page   = s_axis_tdata[63:32];
  assign ctl.ins.offset = s_axis_tdata[95:64];
  assign ctl.query      = query_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign pos[i].in_use = (skti_pkg::CNT_W'(i) < count_q);
    assign pos[i].at_end = (skti_pkg::CNT_W'(i) == count_q);
    if (i == 0) begin : g_head
      assign left[i] = '0;
    end else begin : g_body
      assign left[i] = link[i-1];
    end
    skti_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pos_i  (pos[i]),
      .left_i (left[i]),
      .link_o (link[i]),
      .leaf_o (leaf[i])
    );
  end

  skti_tree u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      skti_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          state_d = skti_pkg::ST_SEARCH;
        end
      end
      skti_pkg::ST_SEARCH: begin
        if (done) begin
          state_d = skti_pkg::ST_IDLE;
        end
      end
      default: state_d = skti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    lat_d         = lat_q;
    query_d       = query_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q & ~m_axis_tready;
    out_status_d  = out_status_q;
    out_page_d    = out_page_q;
    out_offset_d  = out_offset_q;
    case (state_q)
      skti_pkg::ST_IDLE: begin
        s_axis_tready = out_free;
        lat_d         = '0;
        if (accept) begin
          if (is_search) begin
            query_d = s_axis_tdata[31:0];
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = full ? skti_pkg::STATUS_FULL : skti_pkg::STATUS_INSERTED;
            out_page_d   = '0;
            out_offset_d = '0;
            if (ins_en) begin
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      skti_pkg::ST_SEARCH: begin
        // advance until the tree root holds this query
        if (lat_q != skti_pkg::LAT_W'(skti_pkg::LAT)) begin
          lat_d = lat_q + 1'b1;
        end
        if (done) begin
          out_valid_d  = 1'b1;
          out_status_d = root.found ? skti_pkg::STATUS_FOUND : skti_pkg::STATUS_MISSING;
          out_page_d   = root.page;
          out_offset_d = root.offset;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skti_pkg::ST_IDLE;
      count_q     <= '0;
      lat_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lat_q       <= lat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q      <= query_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
    out_offset_q <= out_offset_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_offset_q, out_page_q};
  assign m_axis_tuser  = out_status_q;

endmodule

### hw/rtl/skti_cell.sv
module skti_cell (
  input  logic                  clk_i,
  input  skti_pkg::cell_ctl_t   ctl_i,
  input  skti_pkg::cell_pos_t   pos_i,
  input  skti_pkg::link_t       left_i,
  output skti_pkg::link_t       link_o,
  output skti_pkg::hit_t        leaf_o
);

  skti_pkg::entry_t entry_q, entry_d;
  skti_pkg::hit_t   leaf_q, leaf_d;
  logic             gt, eq, take_new;

  assign gt       = pos_i.in_use & (entry_q.key > ctl_i.ins.key);
  assign eq       = pos_i.in_use & (entry_q.key == ctl_i.query);
  assign take_new = pos_i.in_use ? gt : pos_i.at_end;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en) begin
      if (left_i.gt) begin
        entry_d = left_i.entry;
      end else if (take_new) begin
        entry_d = ctl_i.ins;
      end
    end
  end

  // first of a run of equal keys
  always_comb begin
    leaf_d.found  = eq & ~left_i.eq;
    leaf_d.page   = leaf_d.found ? entry_q.page : '0;
    leaf_d.offset = leaf_d.found ? entry_q.offset : '0;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    leaf_q  <= leaf_d;
  end

  assign link_o.entry = entry_q;
  assign link_o.gt    = gt;
  assign link_o.eq    = eq;
  assign leaf_o       = leaf_q;

endmodule

### hw/rtl/skti_tree.sv
module skti_tree (
  input  logic           clk_i,
  input  skti_pkg::hit_t leaf_i [skti_pkg::CAPACITY],
  output skti_pkg::hit_t root_o
);

  skti_pkg::hit_t node_q [1:skti_pkg::TREE_N-1];
  skti_pkg::hit_t full   [1:2*skti_pkg::TREE_N-1];

  always_comb begin
    for (int k = 1; k < skti_pkg::TREE_N; k++) begin
      full[k] = node_q[k];
    end
    for (int i = 0; i < skti_pkg::TREE_N; i++) begin
      if (i < skti_pkg::CAPACITY) begin
        full[skti_pkg::TREE_N + i] = leaf_i[i];
      end else begin
        full[skti_pkg::TREE_N + i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k < skti_pkg::TREE_N; k++) begin
      node_q[k] <= skti_pkg::hit_or(full[2*k], full[2*k+1]);
    end
  end

  assign root_o = node_q[1];

endmodule

### tb/skti_table_monitor.sv
module skti_table_monitor
  import skti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // key, page_in, offset_in
  input  logic [0:0]  s_axis_tuser,   // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // page_out, offset_out
  input  logic [1:0]  m_axis_tuser,   // status
  output int unsigned fail_count_o,
  output int unsigned waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    status_e     status;
    logic [31:0] page;
    logic [31:0] offset;
  } outcome_t;

  logic [31:0] key_tab [CAPACITY];
  logic [31:0] page_tab [CAPACITY];
  logic [31:0] off_tab [CAPACITY];
  int unsigned fill = 0;
  outcome_t    expected_q [$];
  int unsigned fails = 0;
  int unsigned pending = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  assign fail_count_o = fails;
  assign waiting_o    = pending;

  function automatic outcome_t table_apply(input mode_e mode, input logic [31:0] key,
                                           input logic [31:0] page, input logic [31:0] offset);
    outcome_t    r;
    int unsigned pos;
    r.status = STATUS_MISSING;
    r.page   = '0;
    r.offset = '0;
    if (mode == MODE_INSERT) begin
      if (fill >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        pos = fill;
        while (pos > 0 && key_tab[pos-1] > key) begin
          key_tab[pos]  = key_tab[pos-1];
          page_tab[pos] = page_tab[pos-1];
          off_tab[pos]  = off_tab[pos-1];
          pos--;
        end
        key_tab[pos]  = key;
        page_tab[pos] = page;
        off_tab[pos]  = offset;
        fill++;
        r.status = STATUS_INSERTED;
      end
    end else begin
      pos = 0;
      while (pos < fill && key > key_tab[pos]) pos++;
      if (pos < fill && key_tab[pos] == key) begin
        r.status = STATUS_FOUND;
        r.page   = page_tab[pos];
        r.offset = off_tab[pos];
      end
    end
    return r;
  endfunction

  task automatic flag_result(input string what, input outcome_t want, input outcome_t got);
    fails++;
    if (fails <= REPORT_MAX) begin
      $display("%0t: %s: expected status %0d page %h offset %h, got status %0d page %h offset %h",
               $realtime, what, want.status, want.page, want.offset,
               got.status, got.page, got.offset);
    end
  endtask

  always @(posedge clk_i) begin : watch
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.page   = m_axis_tdata[31:0];
        got.offset = m_axis_tdata[63:32];
        status_seen[m_axis_tuser]++;
        if (expected_q.size() == 0) begin
          want = '0;
          flag_result("result beat with nothing pending", want, got);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.page !== want.page ||
              got.offset !== want.offset) begin
            flag_result("result mismatch", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(table_apply(mode_e'(s_axis_tuser), s_axis_tdata[31:0],
                                         s_axis_tdata[63:32], s_axis_tdata[95:64]));
      end
      pending = expected_q.size();
    end
  end

  task automatic print_summary();
    $display("results: %0d inserted, %0d rejected on full table, %0d hits, %0d misses",
             status_seen[STATUS_INSERTED], status_seen[STATUS_FULL],
             status_seen[STATUS_FOUND], status_seen[STATUS_MISSING]);
    $display("table ended with %0d of %0d entries, %0d mismatches",
             fill, CAPACITY, fails);
  endtask

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import skti_pkg::*;

  localparam int unsigned N_RANDOM    = 1200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN       = 2 * LAT + 4;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;   // key, page_in, offset_in
  logic [0:0]  s_axis_tuser  = MODE_INSERT;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // page_out, offset_out
  logic [1:0]  m_axis_tuser;   // status

  logic        hold_rx = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned fail_count;
  int unsigned waiting;
  logic [31:0] used_keys [$];

  sorted_key_index_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  skti_table_monitor chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .waiting_o     (waiting)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  task automatic push_item(input mode_e mode, input logic [31:0] key,
                           input logic [31:0] page, input logic [31:0] offset);
    int unsigned gap;
    gap = ((items_sent / 80) % 5 == 3) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom(), $urandom(), $urandom()};
      s_axis_tuser  <= 1'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {offset, page, key};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (mode == MODE_INSERT) used_keys.push_back(key);
  endtask

  function automatic logic [31:0] pick_key(input bit probe);
    int unsigned r;
    int unsigned idx;
    logic [31:0] k;
    r   = $urandom_range(0, 99);
    idx = (used_keys.size() != 0) ? $urandom_range(0, used_keys.size() - 1) : 0;
    if (used_keys.size() != 0 && r < (probe ? 50 : 25)) begin
      k = used_keys[idx];
    end else if (used_keys.size() != 0 && r < (probe ? 65 : 30)) begin
      k = ($urandom_range(0, 1) != 0) ? used_keys[idx] + 32'd1 : used_keys[idx] - 32'd1;
    end else if (r < 80) begin
      k = $urandom_range(0, 15);
    end else if (r < 85) begin
      k = r[0] ? '1 : '0;
    end else begin
      k = $urandom();
    end
    return k;
  endfunction

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    push_item(MODE_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(MODE_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    push_item(MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    push_item(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(MODE_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
    push_item(MODE_INSERT, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002);
    push_item(MODE_INSERT, 32'h8000_0000, 32'h0000_0003, 32'h0000_0004);
    push_item(MODE_SEARCH, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
    push_item(MODE_SEARCH, 32'h0000_0000, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'hFFFF_FFFF, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'h7FFF_FFFF, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'h8000_0001, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'h0000_0001, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'hFFFF_FFFE, $urandom(), $urandom());
    push_item(MODE_INSERT, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA);
    push_item(MODE_INSERT, 32'h0000_0000, 32'h0000_0007, 32'h0000_0008);
    push_item(MODE_SEARCH, 32'h0000_0005, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'h0000_0000, $urandom(), $urandom());
    push_item(MODE_SEARCH, 32'h0000_0004, $urandom(), $urandom());
    push_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    push_item(MODE_SEARCH, 32'hFFFF_FFFF, $urandom(), $urandom());

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(MODE_INSERT, pick_key(1'b0), $urandom(), $urandom());
      end else begin
        push_item(MODE_SEARCH, pick_key(1'b1), $urandom(), $urandom());
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    wait (waiting == 0);
    repeat (DRAIN) @(posedge clk_i);
    chk.print_summary();
    $display("%0d beats sent, %0d results taken, receiver held off for %0d cycles once",
             items_sent, results_taken, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        results_taken++;
        stall = ((results_taken / 64) % 4 == 1) ? 0 : $urandom_range(0, 3);
      end
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // hold the result side off so the table backs up into the input
  initial begin
    wait (items_sent >= HOLD_AT);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

endmodule

### sorted_key_index_table_unit.f
hw/rtl/skti_pkg.sv
hw/rtl/skti_cell.sv
hw/rtl/skti_tree.sv
hw/rtl/sorted_key_index_table_unit.sv
tb/skti_table_monitor.sv
tb/testbench.sv
